// ----- sv/et_pkg.sv -----
// Shared types, constants and the microprogram of the Euler totient unit.
// No dependencies; used by every other file of the block.
`default_nettype none

package et_pkg;

    // Operand width and derived sizes
    localparam int VALUE_W = 31;
    localparam int TDATA_W = ((VALUE_W + 7) / 8) * 8;
    localparam int CNT_W   = $clog2(VALUE_W);
    localparam int PC_W    = 4;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [PC_W-1:0]    t_pc;

    // Datapath action of one microstep
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,      // take a request: acc = rest = n, d = 2
        ACT_DIV_RD,    // divide rest by d
        ACT_DIV_AD,    // divide acc by d
        ACT_DIV_AR,    // divide acc by rest
        ACT_REST_Q,    // rest = quotient
        ACT_ACC_SUB,   // acc = acc - quotient
        ACT_INC_D,     // next trial divisor
        ACT_EMIT       // hand acc to the output register
    } t_act;

    // Branch condition of one microstep
    typedef enum logic [2:0] {
        CND_NEXT,      // fall through
        CND_ALWAYS,
        CND_Q_LT_D,    // d > rest / d: trial loop finished
        CND_R_NZ,      // d does not divide
        CND_R_Z,       // d divides again
        CND_REST_LE1   // no leftover prime factor
    } t_cond;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Status flags from the datapath to the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic div_busy;
        logic div_done;
        logic q_lt_d;
        logic r_nz;
        logic rest_le1;
    } t_stat;

    // Command from the sequencer to the datapath
    typedef struct packed {
        t_act act;
        logic fire;       // action takes effect at this edge
        logic div_start;
        logic in_ready;
    } t_cmd;

    // Microprogram entry points
    localparam t_pc PC_FETCH  = 4'd0;
    localparam t_pc PC_TRIAL  = 4'd1;
    localparam t_pc PC_STRIP  = 4'd4;
    localparam t_pc PC_NEXT_D = 4'd9;
    localparam t_pc PC_TAIL   = 4'd10;
    localparam t_pc PC_EMIT   = 4'd13;

    function automatic t_uword uw(input t_act a, input t_cond c, input t_pc t);
        t_uword w;
        w.act    = a;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    // Control store
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            4'd0:    w = uw(ACT_LOAD,    CND_NEXT,     PC_FETCH);
            4'd1:    w = uw(ACT_DIV_RD,  CND_NEXT,     PC_FETCH);
            4'd2:    w = uw(ACT_NONE,    CND_Q_LT_D,   PC_TAIL);
            4'd3:    w = uw(ACT_NONE,    CND_R_NZ,     PC_NEXT_D);
            4'd4:    w = uw(ACT_REST_Q,  CND_NEXT,     PC_FETCH);
            4'd5:    w = uw(ACT_DIV_RD,  CND_NEXT,     PC_FETCH);
            4'd6:    w = uw(ACT_NONE,    CND_R_Z,      PC_STRIP);
            4'd7:    w = uw(ACT_DIV_AD,  CND_NEXT,     PC_FETCH);
            4'd8:    w = uw(ACT_ACC_SUB, CND_NEXT,     PC_FETCH);
            4'd9:    w = uw(ACT_INC_D,   CND_ALWAYS,   PC_TRIAL);
            4'd10:   w = uw(ACT_NONE,    CND_REST_LE1, PC_EMIT);
            4'd11:   w = uw(ACT_DIV_AR,  CND_NEXT,     PC_FETCH);
            4'd12:   w = uw(ACT_ACC_SUB, CND_NEXT,     PC_FETCH);
            4'd13:   w = uw(ACT_EMIT,    CND_ALWAYS,   PC_FETCH);
            default: w = uw(ACT_NONE,    CND_ALWAYS,   PC_FETCH);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- sv/et_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on et_pkg for the operand width.
`default_nettype none

module et_div (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire et_pkg::t_value i_dividend,
    input  wire et_pkg::t_value i_divisor,
    output logic                o_busy,
    output logic                o_done,
    output et_pkg::t_value      o_quot,
    output et_pkg::t_value      o_rem
);
    import et_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_value           r_quo, n_quo;
    t_value           r_rem, n_rem;
    t_value           r_dvs, n_dvs;

    logic [VALUE_W:0] rem_sh;
    logic [VALUE_W:0] diff;

    // One restoring step
    always_comb begin
        rem_sh = {r_rem, r_quo[VALUE_W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(VALUE_W - 1);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (!diff[VALUE_W]) begin
                n_rem = diff[VALUE_W-1:0];
                n_quo = {r_quo[VALUE_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[VALUE_W-1:0];
                n_quo = {r_quo[VALUE_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control flops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Operand flops
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ----- sv/et_seq.sv -----
// Microcode sequencer: step counter, control store lookup, hold and branch logic.
// Depends on et_pkg for the control word, status and command types.
`default_nettype none

module et_seq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire et_pkg::t_stat i_stat,
    output et_pkg::t_cmd       o_cmd
);
    import et_pkg::*;

    t_pc    r_pc, n_pc;
    t_uword word;
    logic   is_div;
    logic   hold;
    logic   take;

    // Decode the current step
    always_comb begin
        word   = ucode(r_pc);
        is_div = (word.act == ACT_DIV_RD) || (word.act == ACT_DIV_AD) ||
                 (word.act == ACT_DIV_AR);
        // a step stalls until its handshake or division completes
        unique case (word.act)
            ACT_LOAD:                          hold = !i_stat.in_valid;
            ACT_EMIT:                          hold = !i_stat.out_free;
            ACT_DIV_RD, ACT_DIV_AD, ACT_DIV_AR: hold = !i_stat.div_done;
            default:                           hold = 1'b0;
        endcase
        unique case (word.cond)
            CND_NEXT:     take = 1'b0;
            CND_ALWAYS:   take = 1'b1;
            CND_Q_LT_D:   take = i_stat.q_lt_d;
            CND_R_NZ:     take = i_stat.r_nz;
            CND_R_Z:      take = !i_stat.r_nz;
            CND_REST_LE1: take = i_stat.rest_le1;
            default:      take = 1'b0;
        endcase
        if (hold)
            n_pc = r_pc;
        else if (take)
            n_pc = word.target;
        else
            n_pc = r_pc + 1'b1;

        o_cmd.act       = word.act;
        o_cmd.fire      = !hold;
        o_cmd.div_start = is_div && !i_stat.div_busy && !i_stat.div_done;
        o_cmd.in_ready  = (word.act == ACT_LOAD);
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

// ----- sv/euler_totient.sv -----
// Euler totient by trial division, one request at a time; a shared divider gives one
// quotient bit a cycle. Trial divisors are 2, then odd ones up to sqrt of the remaining n.
// o_s_tready rises again in the same cycle as o_m_tvalid, so the next request can be
// taken then. Synchronous active-low reset clears the sequencer, the divider control
// and the output valid flag.
`default_nettype none

module euler_totient (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    input  wire logic [et_pkg::TDATA_W-1:0]   i_s_tdata,   // [30:0] n_value, rest zero
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic [et_pkg::TDATA_W-1:0]        o_m_tdata    // [30:0] totient, rest zero
);
    import et_pkg::*;

    t_stat  stat;
    t_cmd   cmd;
    logic   div_busy;
    logic   div_done;
    t_value quot;
    t_value rem;
    t_value dividend;
    t_value divisor;

    t_value r_acc, n_acc;
    t_value r_rest, n_rest;
    t_value r_d, n_d;
    t_value r_out, n_out;
    logic   r_out_valid, n_out_valid;

    et_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    et_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    // Divider operand selection
    assign dividend = (cmd.act == ACT_DIV_RD) ? r_rest : r_acc;
    assign divisor  = (cmd.act == ACT_DIV_AR) ? r_rest : r_d;

    // Status back to the sequencer
    always_comb begin
        stat.in_valid = i_s_tvalid;
        stat.out_free = !r_out_valid || i_m_tready;
        stat.div_busy = div_busy;
        stat.div_done = div_done;
        stat.q_lt_d   = (quot < r_d);
        stat.r_nz     = (rem != '0);
        stat.rest_le1 = (r_rest <= VALUE_W'(1));
    end

    // Datapath registers
    always_comb begin
        n_acc       = r_acc;
        n_rest      = r_rest;
        n_d         = r_d;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_tready;
        if (cmd.fire) begin
            unique case (cmd.act)
                ACT_LOAD: begin
                    n_acc  = i_s_tdata[VALUE_W-1:0];
                    n_rest = i_s_tdata[VALUE_W-1:0];
                    n_d    = VALUE_W'(2);
                end
                ACT_REST_Q:  n_rest = quot;
                ACT_ACC_SUB: n_acc  = r_acc - quot;
                // after 2 only odd divisors can still divide
                ACT_INC_D:   n_d = r_d + ((r_d == VALUE_W'(2)) ? VALUE_W'(1) : VALUE_W'(2));
                ACT_EMIT: begin
                    n_out       = r_acc;
                    n_out_valid = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_rest <= n_rest;
        r_d    <= n_d;
        r_out  <= n_out;
    end

    assign o_s_tready = cmd.in_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = TDATA_W'(r_out);

endmodule

`default_nettype wire

// ----- sv/et_chk.sv -----
// Port-level checker for the Euler totient unit, bound to the top level.
// Depends on et_pkg for the data widths.
`default_nettype none

module et_chk (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_s_tvalid,
    input wire logic                       o_s_tready,
    input wire logic                       o_m_tvalid,
    input wire logic                       i_m_tready,
    input wire logic [et_pkg::TDATA_W-1:0] o_m_tdata
);
    import et_pkg::*;

    // A pending result is never withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result withdrawn while stalled");

    // Reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // One request at a time: no request taken right after another
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while one is in work");

    // Padding above the result field stays zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata >> VALUE_W) == '0))
        else $error("non-zero padding in result");

endmodule

bind euler_totient et_chk u_et_chk (.*);

`default_nettype wire
